// ----- design/bis_pkg.sv -----
package bis_pkg;

   localparam int DEF_MAX_ROWS  = 512;
   localparam int DEF_MAX_COLS  = 512;
   localparam int DEF_FRAC_BITS = 8;

   localparam int STEP_W  = 24;
   localparam int SIZE_W  = 10;
   localparam int IDX_W   = 12;
   localparam int PIX_W   = 24;
   localparam int CSR_A_W = 2;
   localparam int POS_W   = IDX_W + STEP_W;

   localparam logic [CSR_A_W-1:0] CSR_ROWS     = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_COLS     = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_ROW_STEP = 2'd2;
   localparam logic [CSR_A_W-1:0] CSR_COL_STEP = 2'd3;

   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   // Pipeline control passed from the address stage to the blend stage.
   typedef struct packed {
      logic valid;
      logic odd_row;
      logic odd_col;
   } bis_ctl_type;

endpackage

// ----- design/bis_blend.sv -----
module bis_blend
   import bis_pkg::*;
#(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                 clock,
   input  logic [FRAC_BITS-1:0] frac_a,
   input  logic [FRAC_BITS-1:0] frac_b,
   input  logic [PIX_W-1:0]     p00,
   input  logic [PIX_W-1:0]     p10,
   input  logic [PIX_W-1:0]     p01,
   input  logic [PIX_W-1:0]     p11,
   output logic [PIX_W-1:0]     pixel
);

   localparam int WW = 2*FRAC_BITS + 2;
   localparam int AW = WW + 10;
   localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

   logic [WW-1:0] w00_ff, w10_ff, w01_ff, w11_ff;
   logic [PIX_W-1:0] q00_ff, q10_ff, q01_ff, q11_ff;
   logic [FRAC_BITS:0] na, nb;

   // Weight stage: four narrow products of the fractions.
   assign na = ONE - {1'b0, frac_a};
   assign nb = ONE - {1'b0, frac_b};

   always_ff @(posedge clock) begin
      w00_ff <= WW'(na * nb);
      w10_ff <= WW'(na * {1'b0, frac_b});
      w01_ff <= WW'({1'b0, frac_a} * nb);
      w11_ff <= WW'({1'b0, frac_a} * {1'b0, frac_b});
      q00_ff <= p00;
      q10_ff <= p10;
      q01_ff <= p01;
      q11_ff <= p11;
   end

   // Blend stage: per channel weighted sum, truncated.
   always_comb begin
      logic [AW-1:0] acc;
      pixel = '0;
      for (int ch = 0; ch < 3; ch++) begin
         acc = AW'(w00_ff * q00_ff[8*ch +: 8]) + AW'(w10_ff * q10_ff[8*ch +: 8])
             + AW'(w01_ff * q01_ff[8*ch +: 8]) + AW'(w11_ff * q11_ff[8*ch +: 8]);
         pixel[8*ch +: 8] = acc[2*FRAC_BITS +: 8];
      end
   end

endmodule

// ----- design/bilinear_image_scaler.sv -----
// Bilinear image scaler.
// The req_ channel carries writes (opcode 0) that store one source pixel
// in a four-bank frame store, and requests (opcode 1) that name an output
// pixel. Each request gives one rsp_ item holding the blended RGB pixel;
// writes give no response. The csr_ port sets image size and Q8.16 steps;
// the user writes it only while the block is idle; the block does not enforce this.
// Pipeline: multiply, address/clamp with bank read, neighbor routing,
// weights, blend+output.
// A request passes the stage 1, bank read, routing, weight and output
// registers before its response is valid on rsp_. Without a stall, one
// request per cycle is sustained, set by the single read port of each bank
// (the four neighbors always sit in four distinct even/odd banks). When a
// response waits and rsp_tready is low, the pipeline holds as a whole and
// req_tready drops until the output register drains. Reset clears the pipeline
// valid bits and restores the registers to 512 x 512 with unit steps; frame
// store contents are undefined until written, and no clearing pass is needed.
module bilinear_image_scaler
   import bis_pkg::*;
#(
   parameter int MAX_ROWS  = DEF_MAX_ROWS,
   parameter int MAX_COLS  = DEF_MAX_COLS,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // opcode[0], row_index[12:1], col_index[24:13], pixel_in[48:25], zero pad
   input  logic [55:0]        req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // pixel_out[23:0]
   output logic [PIX_W-1:0]   rsp_tdata,
   input  logic               csr_we,
   input  logic [CSR_A_W-1:0] csr_addr,
   input  logic [STEP_W-1:0]  csr_wdata
);

   localparam int RW  = $clog2(MAX_ROWS);
   localparam int CW  = $clog2(MAX_COLS);
   localparam int BRW = (RW > 1) ? RW - 1 : 1;
   localparam int BCW = (CW > 1) ? CW - 1 : 1;
   localparam int BD  = ((MAX_ROWS + 1) / 2) * ((MAX_COLS + 1) / 2);
   localparam int BAW = BRW + BCW;
   localparam int HCOLS = (MAX_COLS + 1) / 2;

   logic [SIZE_W-1:0] rows_ff, cols_ff;
   logic [STEP_W-1:0] rstep_ff, cstep_ff;

   logic advance;
   logic        op;
   logic [IDX_W-1:0] ri, ci;
   logic [PIX_W-1:0] pin;

   // Stage 1 (multiply), 2 (address), 3 (read), 4 (weights), 5 (output).
   logic s1_v_ff, s1_op_ff;
   logic [POS_W-1:0] pr_ff, pc_ff;
   logic [IDX_W-1:0] wr_ff, wc_ff;
   logic [PIX_W-1:0] wp_ff;
   logic [FRAC_BITS-1:0] a2_ff, b2_ff, a3_ff, b3_ff;
   bis_ctl_type c3_ff, c4_ff;
   logic v2_ff;
   logic vb_ff;
   logic v5_ff;
   logic [PIX_W-1:0] out_ff;

   assign op  = req_tdata[0];
   assign ri  = req_tdata[12:1];
   assign ci  = req_tdata[24:13];
   assign pin = req_tdata[48:25];

   assign advance    = !v5_ff || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = out_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= SIZE_W'(512);
         cols_ff  <= SIZE_W'(512);
         rstep_ff <= STEP_W'(65536);
         cstep_ff <= STEP_W'(65536);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_ROWS:     rows_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_COLS:     cols_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_ROW_STEP: rstep_ff <= csr_wdata;
            CSR_COL_STEP: cstep_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage 1: coordinate products.
   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (advance) s1_v_ff <= req_tvalid;
      if (advance) begin
         s1_op_ff <= op;
         pr_ff    <= POS_W'(ri * rstep_ff);
         pc_ff    <= POS_W'(ci * cstep_ff);
         wr_ff    <= ri;
         wc_ff    <= ci;
         wp_ff    <= pin;
      end
   end

   // Stage 2: saturate size, clamp, form bank addresses.
   logic [IDX_W:0] rsat, csat;
   logic [POS_W-16-1:0] ir0, ic0;
   logic [IDX_W:0] ir, ic, ir1, ic1;
   logic clamp;
   always_comb begin
      if (rows_ff < 2) rsat = (IDX_W+1)'(2);
      else if (32'(rows_ff) > MAX_ROWS) rsat = (IDX_W+1)'(MAX_ROWS);
      else rsat = (IDX_W+1)'(rows_ff);
      if (cols_ff < 2) csat = (IDX_W+1)'(2);
      else if (32'(cols_ff) > MAX_COLS) csat = (IDX_W+1)'(MAX_COLS);
      else csat = (IDX_W+1)'(cols_ff);
      ir0 = pr_ff[POS_W-1:16];
      ic0 = pc_ff[POS_W-1:16];
      clamp = (ir0 >= (POS_W-16)'(rsat - 1)) || (ic0 >= (POS_W-16)'(csat - 1));
      ir = clamp ? rsat - (IDX_W+1)'(2) : (IDX_W+1)'(ir0);
      ic = clamp ? csat - (IDX_W+1)'(2) : (IDX_W+1)'(ic0);
      ir1 = ir + (IDX_W+1)'(1);
      ic1 = ic + (IDX_W+1)'(1);
   end

   // Even/odd banking: bank[row parity][col parity]; the four neighbors
   // hit one entry in each bank.
   logic [BRW-1:0] er, orow;
   logic [BCW-1:0] ec, ocol;
   assign er   = ir[0] ? BRW'(ir1 >> 1) : BRW'(ir >> 1);
   assign orow = ir[0] ? BRW'(ir >> 1)  : BRW'(ir1 >> 1);
   assign ec   = ic[0] ? BCW'(ic1 >> 1) : BCW'(ic >> 1);
   assign ocol = ic[0] ? BCW'(ic >> 1)  : BCW'(ic1 >> 1);

   logic [BAW-1:0] ra [4];
   assign ra[0] = BAW'(er * HCOLS + ec);
   assign ra[1] = BAW'(er * HCOLS + ocol);
   assign ra[2] = BAW'(orow * HCOLS + ec);
   assign ra[3] = BAW'(orow * HCOLS + ocol);

   logic wr_ok;
   logic [BAW-1:0] wa;
   logic [1:0] wbank;
   assign wr_ok = s1_v_ff && (s1_op_ff == OP_WRITE) && advance
                  && (32'(wr_ff) < MAX_ROWS) && (32'(wc_ff) < MAX_COLS);
   assign wa    = BAW'(BRW'(wr_ff >> 1) * HCOLS + BCW'(wc_ff >> 1));
   assign wbank = {wr_ff[0], wc_ff[0]};

   logic [PIX_W-1:0] mem0 [BD];
   logic [PIX_W-1:0] mem1 [BD];
   logic [PIX_W-1:0] mem2 [BD];
   logic [PIX_W-1:0] mem3 [BD];
   logic [PIX_W-1:0] rd_ff [4];

   // Four banks, one write and one registered read each. A write and a used
   // read never meet at once, since stage 1 holds only one item.
   always_ff @(posedge clock) begin
      if (wr_ok && wbank == 2'd0) mem0[wa] <= wp_ff;
      if (advance) rd_ff[0] <= mem0[ra[0]];
   end
   always_ff @(posedge clock) begin
      if (wr_ok && wbank == 2'd1) mem1[wa] <= wp_ff;
      if (advance) rd_ff[1] <= mem1[ra[1]];
   end
   always_ff @(posedge clock) begin
      if (wr_ok && wbank == 2'd2) mem2[wa] <= wp_ff;
      if (advance) rd_ff[2] <= mem2[ra[2]];
   end
   always_ff @(posedge clock) begin
      if (wr_ok && wbank == 2'd3) mem3[wa] <= wp_ff;
      if (advance) rd_ff[3] <= mem3[ra[3]];
   end

   assign v2_ff = s1_v_ff && (s1_op_ff == OP_REQUEST);

   always_ff @(posedge clock) begin
      if (reset) c3_ff <= '0;
      else if (advance) begin
         c3_ff.valid   <= v2_ff;
         c3_ff.odd_row <= ir[0];
         c3_ff.odd_col <= ic[0];
      end
      if (advance) begin
         a2_ff <= pc_ff[16-FRAC_BITS +: FRAC_BITS];
         b2_ff <= pr_ff[16-FRAC_BITS +: FRAC_BITS];
      end
   end

   // Route banks back to neighbor positions.
   logic [PIX_W-1:0] ee, eo, oe, oo, p00, p01, p10, p11;
   always_comb begin
      ee = rd_ff[0]; eo = rd_ff[1]; oe = rd_ff[2]; oo = rd_ff[3];
      case ({c3_ff.odd_row, c3_ff.odd_col})
         2'b00:   begin p00 = ee; p01 = eo; p10 = oe; p11 = oo; end
         2'b01:   begin p00 = eo; p01 = ee; p10 = oo; p11 = oe; end
         2'b10:   begin p00 = oe; p01 = oo; p10 = ee; p11 = eo; end
         default: begin p00 = oo; p01 = oe; p10 = eo; p11 = ee; end
      endcase
   end

   logic [PIX_W-1:0] p00_ff, p01_ff, p10_ff, p11_ff;
   always_ff @(posedge clock) begin
      if (reset) c4_ff <= '0;
      else if (advance) c4_ff <= c3_ff;
      if (advance) begin
         p00_ff <= p00; p01_ff <= p01; p10_ff <= p10; p11_ff <= p11;
         a3_ff  <= a2_ff;
         b3_ff  <= b2_ff;
      end
   end

   // The blend unit registers weights internally and has no enable, so hold
   // its inputs by gating with the stall.
   logic [PIX_W-1:0] blended;
   logic [FRAC_BITS-1:0] ga, gb;
   logic [PIX_W-1:0] g00, g01, g10, g11;
   logic [FRAC_BITS-1:0] ha_ff, hb_ff;
   logic [PIX_W-1:0] h00_ff, h01_ff, h10_ff, h11_ff;
   always_ff @(posedge clock) begin
      ha_ff <= ga; hb_ff <= gb;
      h00_ff <= g00; h01_ff <= g01; h10_ff <= g10; h11_ff <= g11;
   end
   assign ga  = advance ? a3_ff  : ha_ff;
   assign gb  = advance ? b3_ff  : hb_ff;
   assign g00 = advance ? p00_ff : h00_ff;
   assign g01 = advance ? p01_ff : h01_ff;
   assign g10 = advance ? p10_ff : h10_ff;
   assign g11 = advance ? p11_ff : h11_ff;

   bis_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
      .clock  (clock),
      .frac_a (ga),
      .frac_b (gb),
      .p00    (g00),
      .p10    (g10),
      .p01    (g01),
      .p11    (g11),
      .pixel  (blended)
   );

   // Output register; the valid bit follows the blend unit's weight stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (advance) begin
         vb_ff <= c4_ff.valid;
         v5_ff <= vb_ff;
      end
      if (advance) out_ff <= blended;
   end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import bis_pkg::*;

   localparam int MAXR = DEF_MAX_ROWS;
   localparam int MAXC = DEF_MAX_COLS;

   typedef struct {
      logic             op;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [PIX_W-1:0] pix;
   } pixel_req_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [55:0]        req_tdata = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [PIX_W-1:0]   rsp_tdata;
   logic               csr_we = 1'b0;
   logic [CSR_A_W-1:0] csr_addr = CSR_ROWS;
   logic [STEP_W-1:0]  csr_wdata = '0;

   bilinear_image_scaler uut (.*);

   // Scaler state as seen by the predictor.
   logic [PIX_W-1:0]  source_frame [MAXR*MAXC];
   bit                planned_written [MAXR*MAXC];
   logic [SIZE_W-1:0] rows_reg = 10'd512;
   logic [SIZE_W-1:0] cols_reg = 10'd512;
   logic [STEP_W-1:0] row_step_reg = 24'h010000;
   logic [STEP_W-1:0] col_step_reg = 24'h010000;

   pixel_req_t        pending_reqs [$];
   logic [PIX_W-1:0]  expected_pixels [$];
   int                errors = 0;
   int                writes_seen = 0;
   int                requests_seen = 0;
   int                pixels_checked = 0;
   int                phases_run = 0;
   bit                req_fired = 1'b0;
   bit                calm = 1'b0;
   int                req_gap = 0;
   int                rsp_gap = 0;

   always #2 clock = ~clock;

   // Map an output coordinate to its top-left source neighbor and fractions.
   function automatic void locate(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                                  output int ir, output int ic,
                                  output int fa, output int fb);
      longint pr, pc;
      int     nr, nc;
      nr = (rows_reg < 2) ? 2 : (rows_reg > MAXR) ? MAXR : rows_reg;
      nc = (cols_reg < 2) ? 2 : (cols_reg > MAXC) ? MAXC : cols_reg;
      pr = longint'(row) * longint'(row_step_reg);
      pc = longint'(col) * longint'(col_step_reg);
      ir = int'(pr >> 16);
      ic = int'(pc >> 16);
      fb = int'((pr >> 8) & 255);
      fa = int'((pc >> 8) & 255);
      if (ir >= nr - 1 || ic >= nc - 1) begin
         ir = nr - 2;
         ic = nc - 2;
      end
   endfunction

   // Bilinear blend of the four neighbors, truncated per channel.
   function automatic logic [PIX_W-1:0] blend_pixel(input logic [IDX_W-1:0] row,
                                                    input logic [IDX_W-1:0] col);
      int               ir, ic, fa, fb;
      longint           w00, w10, w01, w11, acc;
      logic [PIX_W-1:0] p00, p10, p01, p11, result;
      locate(row, col, ir, ic, fa, fb);
      p00 = source_frame[ir*MAXC + ic];
      p10 = source_frame[(ir+1)*MAXC + ic];
      p01 = source_frame[ir*MAXC + ic + 1];
      p11 = source_frame[(ir+1)*MAXC + ic + 1];
      w00 = (256 - fa) * (256 - fb);
      w10 = (256 - fa) * fb;
      w01 = fa * (256 - fb);
      w11 = fa * fb;
      for (int ch = 0; ch < 3; ch++) begin
         acc = w00 * p00[8*ch +: 8] + w10 * p10[8*ch +: 8]
             + w01 * p01[8*ch +: 8] + w11 * p11[8*ch +: 8];
         result[8*ch +: 8] = acc[23:16];
      end
      return result;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic queue_write(input int row, input int col, input logic [PIX_W-1:0] pix);
      pixel_req_t item;
      item.op = OP_WRITE;
      item.row = row;
      item.col = col;
      item.pix = pix;
      if (row < MAXR && col < MAXC) planned_written[row*MAXC + col] = 1'b1;
      pending_reqs.push_back(item);
   endtask

   // Queue a request whose four neighbors are known to be written.
   task automatic queue_request(input int row, input int col);
      pixel_req_t item;
      int         ir, ic, fa, fb;
      locate(row, col, ir, ic, fa, fb);
      if (!(planned_written[ir*MAXC + ic] && planned_written[(ir+1)*MAXC + ic] &&
            planned_written[ir*MAXC + ic + 1] && planned_written[(ir+1)*MAXC + ic + 1])) begin
         row = 0;
         col = 0;
      end
      item.op = OP_REQUEST;
      item.row = row;
      item.col = col;
      item.pix = $urandom;
      pending_reqs.push_back(item);
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || expected_pixels.size() != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_config(input logic [SIZE_W-1:0] r, input logic [SIZE_W-1:0] c,
                             input logic [STEP_W-1:0] rs, input logic [STEP_W-1:0] cs);
      @(negedge clock);
      csr_we <= 1'b1; csr_addr <= CSR_ROWS; csr_wdata <= r;
      @(negedge clock);
      csr_addr <= CSR_COLS; csr_wdata <= c;
      @(negedge clock);
      csr_addr <= CSR_ROW_STEP; csr_wdata <= rs;
      @(negedge clock);
      csr_addr <= CSR_COL_STEP; csr_wdata <= cs;
      @(negedge clock);
      csr_we <= 1'b0;
      rows_reg = r;
      cols_reg = c;
      row_step_reg = rs;
      col_step_reg = cs;
   endtask

   // One phase of random traffic: fill a small region and the far corner, then mostly requests.
   task automatic random_phase(input int n_req);
      int nr, nc, fr, fc, lim_r, lim_c, row, col, pick;
      nr = (rows_reg < 2) ? 2 : (rows_reg > MAXR) ? MAXR : rows_reg;
      nc = (cols_reg < 2) ? 2 : (cols_reg > MAXC) ? MAXC : cols_reg;
      fr = $urandom_range(2, 8); if (fr > nr) fr = nr;
      fc = $urandom_range(2, 8); if (fc > nc) fc = nc;
      for (int r = 0; r < fr; r++)
         for (int c = 0; c < fc; c++) queue_write(r, c, $urandom);
      for (int r = nr - 2; r < nr; r++)
         for (int c = nc - 2; c < nc; c++) queue_write(r, c, $urandom);
      lim_r = (row_step_reg == 0) ? 4095 : (fr << 16) / row_step_reg;
      lim_c = (col_step_reg == 0) ? 4095 : (fc << 16) / col_step_reg;
      if (lim_r > 4095) lim_r = 4095;
      if (lim_c > 4095) lim_c = 4095;
      for (int i = 0; i < n_req; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            queue_write($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom);
         end else if (pick < 16) begin
            queue_write($urandom_range(0, fr - 1), $urandom_range(0, fc - 1), $urandom);
         end else begin
            for (int t = 0; t < 30; t++) begin
               pick = $urandom_range(0, 3);
               row = (pick < 2) ? $urandom_range(0, lim_r) :
                     (pick == 2) ? $urandom_range(0, 4095) : 4095 * $urandom_range(0, 1);
               pick = $urandom_range(0, 3);
               col = (pick < 2) ? $urandom_range(0, lim_c) :
                     (pick == 2) ? $urandom_range(0, 4095) : 4095 * $urandom_range(0, 1);
               begin : check_safe
                  int ir, ic, fa, fb;
                  locate(row, col, ir, ic, fa, fb);
                  if (planned_written[ir*MAXC + ic] && planned_written[(ir+1)*MAXC + ic] &&
                      planned_written[ir*MAXC + ic + 1] &&
                      planned_written[(ir+1)*MAXC + ic + 1]) break;
               end
            end
            queue_request(row, col);
         end
      end
      wait_idle();
      phases_run++;
   endtask

   // Request driver: holds an item until accepted, random gaps between items outside calm phases.
   always @(negedge clock) begin
      pixel_req_t item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fired) begin
         req_tvalid <= 1'b1;
      end else if (req_gap > 0) begin
         req_tvalid <= 1'b0;
         req_gap = req_gap - 1;
      end else if (pending_reqs.size() != 0) begin
         item = pending_reqs.pop_front();
         req_tdata <= {7'd0, item.pix, item.col, item.row, item.op};
         req_tvalid <= 1'b1;
         req_gap = calm ? 0 : pick_gap();
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Response backpressure.
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_tready <= 1'b0;
         rsp_gap = rsp_gap - 1;
      end else begin
         rsp_tready <= 1'b1;
         rsp_gap = calm ? 0 : pick_gap();
      end
   end

   // Monitor: predict on accepted requests, check accepted responses.
   always @(posedge clock) begin
      logic [IDX_W-1:0] row, col;
      logic [PIX_W-1:0] want;
      req_fired <= req_tvalid && req_tready && !reset;
      if (!reset && req_tvalid && req_tready) begin
         row = req_tdata[12:1];
         col = req_tdata[24:13];
         if (req_tdata[0] == OP_WRITE) begin
            writes_seen++;
            if (row < MAXR && col < MAXC) source_frame[row*MAXC + col] = req_tdata[48:25];
         end else begin
            requests_seen++;
            expected_pixels.push_back(blend_pixel(row, col));
         end
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            $error("pixel_out unexpected response %h", rsp_tdata);
            errors++;
         end else begin
            want = expected_pixels.pop_front();
            pixels_checked++;
            if (rsp_tdata !== want) begin
               $error("pixel_out expected %h actual %h", want, rsp_tdata);
               errors++;
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at reset configuration, then at a 3 x 3 size.
      calm = 1'b1;
      queue_write(0, 0, 24'hFFFFFF);
      queue_write(0, 1, 24'h000000);
      queue_write(0, 2, 24'h00FF00);
      queue_write(1, 0, 24'h123456);
      queue_write(1, 1, 24'hFFFFFF);
      queue_write(1, 2, 24'h80807F);
      queue_write(2, 0, 24'h000001);
      queue_write(2, 1, 24'hFEDCBA);
      queue_write(2, 2, 24'h0000FF);
      queue_write(510, 510, 24'hAAAAAA);
      queue_write(510, 511, 24'h555555);
      queue_write(511, 510, 24'hFF0000);
      queue_write(511, 511, 24'h00FFFF);
      queue_write(4095, 4095, 24'hFFFFFF);
      queue_write(512, 0, 24'hFFFFFF);
      queue_write(0, 512, 24'hFFFFFF);
      queue_request(0, 0);
      queue_request(1, 1);
      queue_request(4095, 4095);
      queue_request(511, 0);
      queue_request(0, 4095);
      queue_request(511, 511);
      wait_idle();
      calm = 1'b0;
      set_config(10'd3, 10'd3, 24'h008000, 24'h00C000);
      queue_request(1, 1);
      queue_request(3, 2);
      queue_request(2, 3);
      wait_idle();

      // Random phases over a spread of settings, extremes included.
      set_config(10'd0, 10'd1, 24'h000000, 24'hFFFFFF);
      random_phase(60);
      set_config(10'd1023, 10'd513, 24'h000001, 24'h010000);
      random_phase(60);
      set_config(10'd2, 10'd2, 24'hFFFFFF, 24'h000001);
      random_phase(60);
      set_config(10'd512, 10'd512, 24'h004000, 24'h002A00);
      calm = 1'b1;
      random_phase(60);
      calm = 1'b0;
      for (int p = 0; p < 8; p++) begin
         set_config($urandom_range(2, 16), $urandom_range(2, 16),
                    $urandom_range(1, 24'h030000), $urandom_range(1, 24'h030000));
         random_phase(60);
      end
      set_config($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom, $urandom);
      random_phase(60);

      wait_idle();
      $display("Covered %0d writes and %0d requests over %0d configurations;",
               writes_seen, requests_seen, phases_run + 2);
      $display("%0d output pixels compared, %0d mismatches.", pixels_checked, errors);
      if (errors == 0 && expected_pixels.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
design/bis_pkg.sv
design/bis_blend.sv
design/bilinear_image_scaler.sv
sim/tb_top.sv
